[sv/kmne_pkg.sv]
// ============================================================================
// kmne_pkg
// Shared types and constants for the key-scan MIDI note encoder.
// ============================================================================
`default_nettype none

package kmne_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_PITCH_OFFSET   = 2'd0;
    localparam logic [1:0] CFG_BASE_NOTE      = 2'd1;
    localparam logic [1:0] CFG_MIDI_CHANNEL   = 2'd2;
    localparam logic [1:0] CFG_PRESS_VELOCITY = 2'd3;

    // Reset values of the configuration registers
    localparam logic [6:0] PITCH_OFFSET_RST   = 7'd0;
    localparam logic [6:0] BASE_NOTE_RST      = 7'd12;
    localparam logic [3:0] MIDI_CHANNEL_RST   = 4'd0;
    localparam logic [6:0] PRESS_VELOCITY_RST = 7'd64;

    localparam logic [7:0] NOTE_ON_STATUS = 8'h90;
    localparam logic [6:0] NOTE_MAX       = 7'd127;
    localparam logic [6:0] RELEASE_VEL    = 7'd0;

    // Width of base + offset + key index before saturation
    localparam int SUM_W = 9;

    typedef struct packed {
        logic       has_status;
        logic [7:0] status_byte;
        logic [6:0] note_number;
        logic [6:0] velocity;
    } note_evt_t;

endpackage : kmne_pkg

`default_nettype wire

[sv/key_scan_midi_note_encoder.sv]
// ============================================================================
// key_scan_midi_note_encoder
// Turns successive key scans into MIDI note-on and running-status events.
// ============================================================================
// A scan is accepted only while the block is idle. It is then compared with
// the previous scan and the changed keys are walked one key per clock while
// the output side does not stall the walk: first the pressed keys, then the
// released keys, each pass going through a shift register. One event is held
// back until the next one (or the end of the walk) is found, so that the
// final event can carry last_event. While event_ready is held low, a changed
// key that needs the occupied output register holds the walk.
// Configuration writes take effect at the clock edge at which cfg_write is
// high and must only be issued while the block is idle.
`default_nettype none

module key_scan_midi_note_encoder
    import kmne_pkg::*;
#(
    parameter int NUM_KEYS = 48
) (
    input  wire logic                clk,
    input  wire logic                rst_n,

    input  wire logic                cfg_write,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [6:0]          cfg_data,

    input  wire logic                key_valid,
    output logic                     key_ready,
    input  wire logic [NUM_KEYS-1:0] key_states,

    output logic                     event_valid,
    input  wire logic                event_ready,
    output logic                     has_status,
    output logic [7:0]               status_byte,
    output logic [6:0]               note_number,
    output logic [6:0]               velocity,
    output logic                     last_event
);

    localparam int KW = $clog2(NUM_KEYS);
    localparam logic [KW-1:0] LAST_KEY = KW'(NUM_KEYS - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [NUM_KEYS-1:0] prev_keys_reg, prev_keys_next;
    logic [NUM_KEYS-1:0] press_sr_reg, press_sr_next;
    logic [NUM_KEYS-1:0] release_sr_reg, release_sr_next;
    logic [KW-1:0]       key_cnt_reg, key_cnt_next;
    logic                phase_reg, phase_next;
    logic                first_reg, first_next;
    logic                pend_valid_reg, pend_valid_next;
    note_evt_t           pend_reg, pend_next;
    logic                out_valid_reg, out_valid_next;
    note_evt_t           out_reg, out_next;
    logic                out_last_reg, out_last_next;

    logic [6:0] pitch_offset_reg;
    logic [6:0] base_note_reg;
    logic [3:0] midi_channel_reg;
    logic [6:0] press_velocity_reg;

    logic             cur_bit;
    logic             out_free;
    logic [SUM_W-1:0] note_sum;
    logic [6:0]       cur_note;

    always_comb
    begin
        cur_bit  = phase_reg ? release_sr_reg[0] : press_sr_reg[0];
        out_free = !out_valid_reg || event_ready;
        note_sum = SUM_W'(base_note_reg) + SUM_W'(pitch_offset_reg) + SUM_W'(key_cnt_reg);
        cur_note = (note_sum > SUM_W'(NOTE_MAX)) ? NOTE_MAX : note_sum[6:0];
    end

    always_comb
    begin
        state_next      = state_reg;
        prev_keys_next  = prev_keys_reg;
        press_sr_next   = press_sr_reg;
        release_sr_next = release_sr_reg;
        key_cnt_next    = key_cnt_reg;
        phase_next      = phase_reg;
        first_next      = first_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !event_ready;
        out_next        = out_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (key_valid)
                begin
                    press_sr_next   = key_states & ~prev_keys_reg;
                    release_sr_next = prev_keys_reg & ~key_states;
                    prev_keys_next  = key_states;
                    key_cnt_next    = '0;
                    phase_next      = 1'b0;
                    first_next      = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // A changed key with an event already held back needs the
                // output register; wait while it is still occupied.
                if (!(cur_bit && pend_valid_reg && !out_free))
                begin
                    if (cur_bit)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_next       = pend_reg;
                            out_last_next  = 1'b0;
                            out_valid_next = 1'b1;
                        end
                        pend_next.has_status  = first_reg;
                        pend_next.status_byte = first_reg ?
                                                (NOTE_ON_STATUS | {4'd0, midi_channel_reg}) :
                                                8'd0;
                        pend_next.note_number = cur_note;
                        pend_next.velocity    = phase_reg ? RELEASE_VEL : press_velocity_reg;
                        pend_valid_next       = 1'b1;
                        first_next            = 1'b0;
                    end

                    if (phase_reg)
                    begin
                        release_sr_next = release_sr_reg >> 1;
                    end
                    else
                    begin
                        press_sr_next = press_sr_reg >> 1;
                    end

                    if (key_cnt_reg == LAST_KEY)
                    begin
                        key_cnt_next = '0;
                        if (phase_reg)
                        begin
                            state_next = ST_FLUSH;
                        end
                        else
                        begin
                            phase_next = 1'b1;
                        end
                    end
                    else
                    begin
                        key_cnt_next = key_cnt_reg + 1'b1;
                    end
                end
            end

            ST_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_next        = pend_reg;
                    out_last_next   = 1'b1;
                    out_valid_next  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            prev_keys_reg  <= '0;
            key_cnt_reg    <= '0;
            phase_reg      <= 1'b0;
            first_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            prev_keys_reg  <= prev_keys_next;
            key_cnt_reg    <= key_cnt_next;
            phase_reg      <= phase_next;
            first_reg      <= first_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        press_sr_reg   <= press_sr_next;
        release_sr_reg <= release_sr_next;
        pend_reg       <= pend_next;
        out_reg        <= out_next;
        out_last_reg   <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pitch_offset_reg   <= PITCH_OFFSET_RST;
            base_note_reg      <= BASE_NOTE_RST;
            midi_channel_reg   <= MIDI_CHANNEL_RST;
            press_velocity_reg <= PRESS_VELOCITY_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_PITCH_OFFSET:   pitch_offset_reg   <= cfg_data;
                CFG_BASE_NOTE:      base_note_reg      <= cfg_data;
                CFG_MIDI_CHANNEL:   midi_channel_reg   <= cfg_data[3:0];
                CFG_PRESS_VELOCITY: press_velocity_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    assign key_ready   = (state_reg == ST_IDLE);
    assign event_valid = out_valid_reg;
    assign has_status  = out_reg.has_status;
    assign status_byte = out_reg.status_byte;
    assign note_number = out_reg.note_number;
    assign velocity    = out_reg.velocity;
    assign last_event  = out_last_reg;

endmodule : key_scan_midi_note_encoder

`default_nettype wire

[sv/kmne_checker.sv]
// ============================================================================
// kmne_checker
// Port-level checks for the key-scan MIDI note encoder.
// ============================================================================
`default_nettype none

module kmne_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       key_valid,
    input wire logic       key_ready,
    input wire logic       event_valid,
    input wire logic       event_ready,
    input wire logic       has_status,
    input wire logic [7:0] status_byte,
    input wire logic [6:0] note_number,
    input wire logic [6:0] velocity,
    input wire logic       last_event
);

    // A stalled event keeps its payload until the transfer.
    a_event_hold: assert property (@(posedge clk) disable iff (!rst_n)
        event_valid && !event_ready |=> event_valid && $stable(note_number)
            && $stable(velocity) && $stable(has_status) && $stable(last_event))
        else $error("event payload changed while stalled");

    // A new scan is never taken while events of the previous scan other than its last event are pending.
    a_no_accept_mid_scan: assert property (@(posedge clk) disable iff (!rst_n)
        event_valid && !last_event |-> !key_ready)
        else $error("scan accepted before its predecessor finished");

    // The block is not ready in the cycle after it takes a scan.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        key_valid && key_ready |=> !key_ready)
        else $error("ready stayed high after a scan transfer");

    // Running-status events carry no status byte.
    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        event_valid && !has_status |-> status_byte == 8'd0)
        else $error("status byte set on a running-status event");

endmodule : kmne_checker

bind key_scan_midi_note_encoder kmne_checker u_kmne_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .key_valid   (key_valid),
    .key_ready   (key_ready),
    .event_valid (event_valid),
    .event_ready (event_ready),
    .has_status  (has_status),
    .status_byte (status_byte),
    .note_number (note_number),
    .velocity    (velocity),
    .last_event  (last_event)
);

`default_nettype wire
